/* hdl/edm5_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// edm5_pkg
// Shared widths, reset constants and the link type between sorting cells of
// the echo distance median filter.
// ----------------------------------------------------------------------------
package edm5_pkg;

	localparam int DIST_W = 9;
	localparam int GROUP_SIZE_DEF = 5;
	localparam logic [DIST_W-1:0] NO_ECHO_RESET = 9'd400;

	// What one cell hands to its upper neighbour: its held value and whether
	// the incoming sample sorts below that value (or the cell is empty).
	typedef struct packed {
		logic [DIST_W-1:0] value;
		logic              lt;
	} edm5_link_t;

endpackage
`default_nettype wire

/* hdl/edm5_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// edm5_cell
// One slot of the insertion-sort chain. Holds one sample; on a shift it
// keeps its value, takes the new sample, or takes its lower neighbour's value.
// ----------------------------------------------------------------------------
module edm5_cell import edm5_pkg::*; #(
	parameter int CNT_W = 3,
	parameter int INDEX = 0
) (
	input  wire logic              clk,
	input  wire logic              shift_en,
	input  wire logic [CNT_W-1:0]  cnt,
	input  wire logic [DIST_W-1:0] sample,
	input  wire edm5_link_t        link_in,
	output      edm5_link_t        link_out,
	output      logic [DIST_W-1:0] value_next
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [DIST_W-1:0] value_q;
	logic              empty;
	logic              lt;

	// slots at or above the fill count hold nothing and sort as infinity
	assign empty = (cnt <= IDX);
	assign lt    = empty || (sample < value_q);

	always_comb begin
		if (!lt) begin
			value_next = value_q;
		end else if (link_in.lt) begin
			value_next = link_in.value;
		end else begin
			value_next = sample;
		end
	end

	assign link_out.value = value_q;
	assign link_out.lt    = lt;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= value_next;
		end
	end

endmodule
`default_nettype wire

/* hdl/echo_distance_median_of_five_top.sv */
// The median of a group is registered and presented in the cycle after its last item.
// Throughput: one item per cycle while the input is not stalled; the chain of cells
// sorts each sample as it enters, so each group of GROUP_SIZE items yields one result.
// Input stalls only when a group completes while the previous result is held.
// Reset: counters and output valid clear, no-echo distance returns to 400 cm;
// sample cells are not reset and hold nothing until written.
`default_nettype none
// ----------------------------------------------------------------------------
// echo_distance_median_of_five_top
// Replaces no-echo samples, sorts each group in a chain of cells and gives
// the group median with a flag telling whether any sample had an echo.
// ----------------------------------------------------------------------------
module echo_distance_median_of_five_top import edm5_pkg::*; #(
	parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [DIST_W-1:0] cfg_wr_data,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [DIST_W-1:0] distance_cm,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic [DIST_W-1:0] median_cm,
	output      logic              reading_valid
);

	localparam int CNT_W = $clog2(GROUP_SIZE);
	localparam int MED_IDX = GROUP_SIZE / 2;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GROUP_SIZE - 1);

	logic [DIST_W-1:0] no_echo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              echo_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] median_q;
	logic              reading_valid_q;

	logic              accept;
	logic              last;
	logic              echo;
	logic [DIST_W-1:0] sample;

	edm5_link_t        link [GROUP_SIZE+1];
	logic [DIST_W-1:0] value_next [GROUP_SIZE];

	assign echo   = (distance_cm != '0);
	assign sample = echo ? distance_cm : no_echo_q;
	assign last   = (cnt_q == LAST_CNT);
	// hold the closing item of a group while the previous result waits
	assign in_stall = out_valid_q && out_stall && last;
	assign accept   = in_valid && !in_stall;

	assign link[0].value = '0;
	assign link[0].lt    = 1'b0;

	for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
		edm5_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.shift_en   (accept),
			.cnt        (cnt_q),
			.sample     (sample),
			.link_in    (link[i]),
			.link_out   (link[i+1]),
			.value_next (value_next[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_echo_q <= NO_ECHO_RESET;
		end else if (cfg_wr_en) begin
			no_echo_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			echo_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cnt_q  <= '0;
				echo_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_q + 1'b1;
				echo_q <= echo_q || echo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// tap the median slot as it settles with the closing item
	always_ff @(posedge clk) begin
		if (accept && last) begin
			median_q        <= value_next[MED_IDX];
			reading_valid_q <= echo_q || echo;
		end
	end

	assign out_valid     = out_valid_q;
	assign median_cm     = median_q;
	assign reading_valid = reading_valid_q;

	a_group_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> out_valid_q)
		else $error("closing item of a group gave no result");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("fill count did not advance on an item");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(cnt_q))
		else $error("fill count moved without an item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && last)
		else $error("input stalled without a pending result");

	a_result_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !(accept && last) |=> !out_valid_q)
		else $error("taken result was repeated");

endmodule
`default_nettype wire
